[rtl/ppc_pkg.sv]
// Shared types and constants for the polygon point containment block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package ppc_pkg;
  localparam int MaxVertices = 256;
  localparam int CoordBits   = 16;
  localparam int AddrBits    = $clog2(MaxVertices);
  localparam int CountBits   = $clog2(MaxVertices + 1);
  localparam int VertBits    = 2 * CoordBits;
  localparam int MinPolyVerts = 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic                capture;   // take the request fields
    logic                do_clear;
    logic                do_append;
    logic                rd_en;     // issue a store read
    logic [AddrBits-1:0] rd_addr;
    logic                edge_prev; // latch read data as previous vertex
    logic                edge_eval; // evaluate one edge against the point
    logic                prod_eval; // finish the product compare of that edge
    logic                test_init; // clear crossing parity, latch gate
    logic                finish;    // load the output register
  } ppc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0]           op;
    logic [CountBits-1:0] count;
    logic                 gate_ok;  // enough vertices and inside the box
  } ppc_stat_t;
endpackage

[rtl/polygon_point_containment_top.sv]
// Top level of the polygon point containment block: controller plus datapath.
// Depends on ppc_pkg, ppc_ctrl, ppc_dp and ppc_ram.
//
//   channel | direction | handshake           | fields
//   in_     | input     | in_valid, in_stall  | op, x_coord, y_coord
//   out_    | output    | out_valid, out_stall| inside_res, vertex_total, store_full, box
//
// Clear, append and a gated-off test pass from acceptance through decode to the
// final state, which loads the result. A full point test walks the edges with one
// store read per edge, set by the single read port of the vertex store, plus setup and product settling.
// Reset empties the polygon and the box at once; the store needs no clearing.
// A new request may be taken while a result waits; the block then holds in its
// final state until that result is delivered.
`timescale 1ns / 1ps
module polygon_point_containment_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  ppc_pkg::coord_t                   in_x_coord,
  input  ppc_pkg::coord_t                   in_y_coord,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_inside_res,
  output logic [ppc_pkg::CountBits-1:0]     out_vertex_total,
  output logic                              out_store_full,
  output ppc_pkg::coord_t                   out_box_min_x,
  output ppc_pkg::coord_t                   out_box_min_y,
  output ppc_pkg::coord_t                   out_box_max_x,
  output ppc_pkg::coord_t                   out_box_max_y
);
  ppc_pkg::ppc_cmd_t  cmd;
  ppc_pkg::ppc_stat_t stat;

  ppc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  ppc_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_op(in_op), .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .cmd(cmd), .stat(stat),
    .out_inside_res(out_inside_res), .out_vertex_total(out_vertex_total),
    .out_store_full(out_store_full),
    .out_box_min_x(out_box_min_x), .out_box_min_y(out_box_min_y),
    .out_box_max_x(out_box_max_x), .out_box_max_y(out_box_max_y)
  );
endmodule

[rtl/ppc_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ppc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

[rtl/ppc_ctrl.sv]
// Sequencer for the polygon point containment block: handshakes and the edge walk.
// Depends on ppc_pkg.
`timescale 1ns / 1ps
module ppc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ppc_pkg::ppc_stat_t   stat,
  output ppc_pkg::ppc_cmd_t    cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_PREV = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_LAST = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [ppc_pkg::CountBits-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [ppc_pkg::CountBits-1:0] last_idx;
  assign last_idx = stat.count - ppc_pkg::CountBits'(1);

  // Output register frees up when empty or being taken.
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op == ppc_pkg::OP_TEST && stat.gate_ok) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = last_idx[ppc_pkg::AddrBits-1:0];
          cmd.test_init = 1'b1;
          state_nxt   = S_PREV;
        end else begin
          cmd.do_clear  = (stat.op == ppc_pkg::OP_CLEAR);
          cmd.do_append = (stat.op == ppc_pkg::OP_APPEND);
          cmd.test_init = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_PREV: begin
        cmd.edge_prev = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = '0;
        idx_nxt       = ppc_pkg::CountBits'(1);
        state_nxt     = S_WALK;
      end
      S_WALK: begin
        // Read data holds vertex idx_r-1; evaluate its edge, fetch the next.
        cmd.edge_eval = 1'b1;
        cmd.prod_eval = 1'b1;
        if (idx_r == stat.count) begin
          state_nxt = S_LAST;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = idx_r[ppc_pkg::AddrBits-1:0];
          idx_nxt     = idx_r + ppc_pkg::CountBits'(1);
        end
      end
      S_LAST: begin
        // Product compare of the final edge settles here.
        cmd.prod_eval = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

[rtl/ppc_dp.sv]
// Datapath: vertex store, bounding box, edge crossing test and result register.
// Depends on ppc_pkg and ppc_ram.
`timescale 1ns / 1ps
module ppc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_op,
  input  ppc_pkg::coord_t                   in_x_coord,
  input  ppc_pkg::coord_t                   in_y_coord,
  input  ppc_pkg::ppc_cmd_t                 cmd,
  output ppc_pkg::ppc_stat_t                stat,
  output logic                              out_inside_res,
  output logic [ppc_pkg::CountBits-1:0]     out_vertex_total,
  output logic                              out_store_full,
  output ppc_pkg::coord_t                   out_box_min_x,
  output ppc_pkg::coord_t                   out_box_min_y,
  output ppc_pkg::coord_t                   out_box_max_x,
  output ppc_pkg::coord_t                   out_box_max_y
);
  localparam int CB = ppc_pkg::CoordBits;
  localparam int DB = CB + 1;       // width of a coordinate difference
  localparam int PB = 2 * DB;       // width of a product

  logic [1:0] op_r;
  ppc_pkg::coord_t px_r, py_r;
  logic [ppc_pkg::CountBits-1:0] count_r;
  ppc_pkg::coord_t minx_r, miny_r, maxx_r, maxy_r;
  logic full_r, inside_r, parity_r, gate_r, refused_r;

  // Result register, loaded only when the previous result has been taken.
  logic [ppc_pkg::CountBits-1:0] total_r;
  ppc_pkg::coord_t bminx_r, bminy_r, bmaxx_r, bmaxy_r;

  ppc_pkg::coord_t pvx_r, pvy_r;
  logic [ppc_pkg::VertBits-1:0] rd_data;

  // Product stage registers for one edge.
  logic signed [PB-1:0] lhs_r, rhs_r;
  logic                 pend_r;

  logic is_full, gate;
  assign is_full = (count_r == ppc_pkg::CountBits'(ppc_pkg::MaxVertices));
  assign gate = (count_r >= ppc_pkg::CountBits'(ppc_pkg::MinPolyVerts)) &&
                !(px_r < minx_r) && (px_r < maxx_r) &&
                !(py_r < miny_r) && (py_r < maxy_r);

  assign stat.op      = op_r;
  assign stat.count   = count_r;
  assign stat.gate_ok = gate;

  ppc_ram #(.Width(ppc_pkg::VertBits), .Depth(ppc_pkg::MaxVertices)) u_store (
    .clk     (clk),
    .wr_en   (cmd.do_append && !is_full),
    .wr_addr (count_r[ppc_pkg::AddrBits-1:0]),
    .wr_data ({px_r, py_r}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  ppc_pkg::coord_t cx, cy;
  assign cx = rd_data[ppc_pkg::VertBits-1:CB];
  assign cy = rd_data[CB-1:0];

  // Edge decision from previous vertex (pvx,pvy) to current (cx,cy).
  logic e_skip, e_hit, e_prod;
  ppc_pkg::coord_t left;
  logic signed [DB-1:0] t1, t2, dy, dx;
  always_comb begin
    e_skip = 1'b0;
    e_hit  = 1'b0;
    e_prod = 1'b0;
    left   = (cx < pvx_r) ? cx : pvx_r;
    t1 = '0; t2 = '0;
    dy = DB'(pvy_r) - DB'(cy);
    dx = DB'(pvx_r) - DB'(cx);
    if (dy < 0) begin
      dy = -dy;
      dx = -dx;
    end
    if (cy == pvy_r) e_skip = 1'b1;
    else if ((cx < pvx_r) ? !(px_r < pvx_r) : !(px_r < cx)) e_skip = 1'b1;
    else if ((cy < pvy_r) ? ((py_r < cy) || !(py_r < pvy_r))
                          : ((py_r < pvy_r) || !(py_r < cy))) e_skip = 1'b1;
    if (!e_skip) begin
      if (px_r < left) e_hit = 1'b1;
      else e_prod = 1'b1;
    end
    if (cy < pvy_r) begin
      t1 = DB'(px_r) - DB'(cx);
      t2 = DB'(py_r) - DB'(cy);
    end else begin
      t1 = DB'(px_r) - DB'(pvx_r);
      t2 = DB'(py_r) - DB'(pvy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      minx_r <= '0; miny_r <= '0; maxx_r <= '0; maxy_r <= '0;
      pend_r <= 1'b0;
      parity_r <= 1'b0;
    end else begin
      if (cmd.do_clear) begin
        count_r <= '0;
        minx_r <= '0; miny_r <= '0; maxx_r <= '0; maxy_r <= '0;
      end else if (cmd.do_append && !is_full) begin
        count_r <= count_r + ppc_pkg::CountBits'(1);
        if (count_r == '0) begin
          minx_r <= px_r; maxx_r <= px_r; miny_r <= py_r; maxy_r <= py_r;
        end else begin
          if (px_r < minx_r) minx_r <= px_r;
          if (px_r > maxx_r) maxx_r <= px_r;
          if (py_r < miny_r) miny_r <= py_r;
          if (py_r > maxy_r) maxy_r <= py_r;
        end
      end
      if (cmd.test_init) begin
        parity_r <= 1'b0;
        pend_r   <= 1'b0;
      end else begin
        // Products computed last cycle resolve this cycle; hits toggle parity.
        logic hit_now;
        hit_now = (cmd.edge_eval && e_hit) ^ (cmd.prod_eval && pend_r && (lhs_r < rhs_r));
        if (hit_now) parity_r <= !parity_r;
        pend_r <= cmd.edge_eval && e_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      px_r <= in_x_coord;
      py_r <= in_y_coord;
    end
    if (cmd.test_init) begin
      gate_r    <= gate && (op_r == ppc_pkg::OP_TEST);
      // Noted at decode, before an accepted append can fill the store.
      refused_r <= (op_r == ppc_pkg::OP_APPEND) && is_full;
    end
    if (cmd.edge_prev) begin
      pvx_r <= cx;
      pvy_r <= cy;
    end
    if (cmd.edge_eval) begin
      pvx_r <= cx;
      pvy_r <= cy;
      lhs_r <= t1 * dy;
      rhs_r <= t2 * dx;
    end
    if (cmd.finish) begin
      inside_r <= gate_r && parity_r;
      full_r   <= refused_r;
      total_r  <= count_r;
      bminx_r  <= minx_r;
      bminy_r  <= miny_r;
      bmaxx_r  <= maxx_r;
      bmaxy_r  <= maxy_r;
    end
  end

  assign out_inside_res   = inside_r;
  assign out_store_full   = full_r;
  assign out_vertex_total = total_r;
  assign out_box_min_x    = bminx_r;
  assign out_box_min_y    = bminy_r;
  assign out_box_max_x    = bmaxx_r;
  assign out_box_max_y    = bmaxy_r;
endmodule

[bench/polygon_point_containment_top_test.sv]
// Self-checking bench for polygon_point_containment_top: a local even-odd
// predictor, random stall and idle on both channels. Also depends on ppc_pkg.
`timescale 1ns / 1ps
module polygon_point_containment_top_test;
  localparam int WatchLimit = 20000;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic                          in_poly;
    logic [ppc_pkg::CountBits-1:0] total;
    logic                          full;
    ppc_pkg::coord_t               min_x;
    ppc_pkg::coord_t               min_y;
    ppc_pkg::coord_t               max_x;
    ppc_pkg::coord_t               max_y;
  } poly_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = ppc_pkg::OP_CLEAR;
  ppc_pkg::coord_t in_x_coord = '0;
  ppc_pkg::coord_t in_y_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_inside_res;
  logic [ppc_pkg::CountBits-1:0] out_vertex_total;
  logic out_store_full;
  ppc_pkg::coord_t out_box_min_x, out_box_min_y, out_box_max_x, out_box_max_y;

  always #5 clk = ~clk;

  polygon_point_containment_top u_top (.*);

  // Shadow copy of the polygon.
  ppc_pkg::coord_t poly_x[ppc_pkg::MaxVertices];
  ppc_pkg::coord_t poly_y[ppc_pkg::MaxVertices];
  int unsigned poly_count;
  ppc_pkg::coord_t bmin_x, bmin_y, bmax_x, bmax_y;

  poly_result_t pending_results[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned watch_count = 0;
  int unsigned inside_points = 0;
  int unsigned refused_appends = 0;
  int unsigned tested_points;

  // Even-odd parity of edge crossings; exact sign of a*b < c*d, all operands fit easily in 64 bits.
  function automatic logic crosses_edge(longint px, longint py);
    longint lx, ly, cx, cy, pvx, pvy, lft, t1, t2, dx, dy;
    int unsigned hits;
    hits = 0;
    lx = longint'(poly_x[poly_count-1]);
    ly = longint'(poly_y[poly_count-1]);
    for (int unsigned i = 0; i < poly_count; i++) begin
      cx = longint'(poly_x[i]);
      cy = longint'(poly_y[i]);
      pvx = lx;
      pvy = ly;
      lx = cx;
      ly = cy;
      if (cy == pvy) continue;
      if (cx < pvx) begin
        if (px >= pvx) continue;
        lft = cx;
      end else begin
        if (px >= cx) continue;
        lft = pvx;
      end
      if (cy < pvy) begin
        if (py < cy || py >= pvy) continue;
        t1 = px - cx;
        t2 = py - cy;
      end else begin
        if (py < pvy || py >= cy) continue;
        t1 = px - pvx;
        t2 = py - pvy;
      end
      if (px < lft) begin
        hits++;
        continue;
      end
      dy = pvy - cy;
      dx = pvx - cx;
      if (dy < 0) begin
        dy = -dy;
        dx = -dx;
      end
      if (t1 * dy < t2 * dx) hits++;
    end
    return hits[0];
  endfunction

  function automatic poly_result_t predict_polygon(logic [1:0] op, ppc_pkg::coord_t x,
                                                   ppc_pkg::coord_t y);
    poly_result_t r;
    r = '0;
    case (op)
      ppc_pkg::OP_CLEAR: begin
        poly_count = 0;
        bmin_x = '0; bmin_y = '0; bmax_x = '0; bmax_y = '0;
      end
      ppc_pkg::OP_APPEND: begin
        if (poly_count >= ppc_pkg::MaxVertices) begin
          r.full = 1'b1;
        end else begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          if (poly_count == 0) begin
            bmin_x = x; bmax_x = x; bmin_y = y; bmax_y = y;
          end else begin
            if (x < bmin_x) bmin_x = x;
            if (x > bmax_x) bmax_x = x;
            if (y < bmin_y) bmin_y = y;
            if (y > bmax_y) bmax_y = y;
          end
          poly_count++;
        end
      end
      ppc_pkg::OP_TEST: begin
        if (poly_count >= ppc_pkg::MinPolyVerts && x >= bmin_x && x < bmax_x &&
            y >= bmin_y && y < bmax_y)
          r.in_poly = crosses_edge(longint'(x), longint'(y));
      end
      default: ;
    endcase
    r.total = ppc_pkg::CountBits'(poly_count);
    r.min_x = bmin_x; r.min_y = bmin_y; r.max_x = bmax_x; r.max_y = bmax_y;
    return r;
  endfunction

  // in_valid stays high after an accepted request unless the sender idles.
  task automatic send_request(logic [1:0] op, int x, int y);
    ppc_pkg::coord_t xc, yc;
    xc = ppc_pkg::coord_t'(x);
    yc = ppc_pkg::coord_t'(y);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_x_coord <= xc;
    in_y_coord <= yc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_polygon(op, xc, yc));
    if (op == ppc_pkg::OP_TEST) tested_points++;
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    poly_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.in_poly) inside_points++;
          if (exp_r.full) refused_appends++;
          if (out_inside_res !== exp_r.in_poly) begin
            $error("inside_res exp %0d got %0d", exp_r.in_poly, out_inside_res);
            error_count++;
          end
          if (out_vertex_total !== exp_r.total) begin
            $error("vertex_total exp %0d got %0d", exp_r.total, out_vertex_total);
            error_count++;
          end
          if (out_store_full !== exp_r.full) begin
            $error("store_full exp %0d got %0d", exp_r.full, out_store_full);
            error_count++;
          end
          if (out_box_min_x !== exp_r.min_x) begin
            $error("box_min_x exp %0d got %0d", exp_r.min_x, out_box_min_x);
            error_count++;
          end
          if (out_box_min_y !== exp_r.min_y) begin
            $error("box_min_y exp %0d got %0d", exp_r.min_y, out_box_min_y);
            error_count++;
          end
          if (out_box_max_x !== exp_r.max_x) begin
            $error("box_max_x exp %0d got %0d", exp_r.max_x, out_box_max_x);
            error_count++;
          end
          if (out_box_max_y !== exp_r.max_y) begin
            $error("box_max_y exp %0d got %0d", exp_r.max_y, out_box_max_y);
            error_count++;
          end
        end
      end
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) watch_count <= 0;
    else watch_count <= watch_count + 1;
    if (watch_count >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int rand_coord();
    case ($urandom_range(5))
      0: return -32768;
      1: return 32767;
      default: return int'(ppc_pkg::coord_t'($urandom));
    endcase
  endfunction

  task automatic test_directed();
    send_request(ppc_pkg::OP_TEST, 0, 0);
    send_request(ppc_pkg::OP_APPEND, -32768, -32768);
    send_request(ppc_pkg::OP_APPEND, 32767, -32768);
    send_request(ppc_pkg::OP_TEST, 0, 0);
    send_request(ppc_pkg::OP_APPEND, 0, 32767);
    send_request(ppc_pkg::OP_TEST, 0, 0);
    send_request(ppc_pkg::OP_TEST, -32768, -32768);
    send_request(ppc_pkg::OP_TEST, 32767, 0);
    send_request(ppc_pkg::OP_TEST, 0, 32767);
    send_request(ppc_pkg::OP_TEST, -32767, -32767);
    send_request(OP_NOP, 21845, -21846);
    send_request(ppc_pkg::OP_CLEAR, -1, -1);
    // Square with horizontal and vertical edges.
    send_request(ppc_pkg::OP_APPEND, -10, -10);
    send_request(ppc_pkg::OP_APPEND, 10, -10);
    send_request(ppc_pkg::OP_APPEND, 10, 10);
    send_request(ppc_pkg::OP_APPEND, -10, 10);
    send_request(ppc_pkg::OP_TEST, -10, -10);
    send_request(ppc_pkg::OP_TEST, 9, 9);
    send_request(ppc_pkg::OP_TEST, 0, 10);
    send_request(ppc_pkg::OP_CLEAR, 0, 0);
  endtask

  task automatic test_full_store();
    send_request(ppc_pkg::OP_CLEAR, 0, 0);
    for (int i = 0; i < ppc_pkg::MaxVertices + 2; i++)
      send_request(ppc_pkg::OP_APPEND, int'($urandom_range(200)) - 100,
                   int'(ppc_pkg::coord_t'($urandom)));
    send_request(ppc_pkg::OP_TEST, 0, 0);
    send_request(ppc_pkg::OP_TEST, 5, -7);
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sent, nverts;
    sent = 0;
    while (sent < items) begin
      send_request(ppc_pkg::OP_CLEAR, rand_coord(), rand_coord());
      nverts = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(3, 8);
      for (int i = 0; i < nverts; i++) begin
        if ($urandom_range(1)) send_request(ppc_pkg::OP_APPEND, rand_coord(), rand_coord());
        else send_request(ppc_pkg::OP_APPEND, int'($urandom_range(40)) - 20,
                          int'($urandom_range(40)) - 20);
      end
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(9))
          0: send_request(OP_NOP, rand_coord(), rand_coord());
          1: send_request(ppc_pkg::OP_TEST, rand_coord(), rand_coord());
          2, 3, 4: send_request(ppc_pkg::OP_TEST, int'($urandom_range(40)) - 20,
                                int'($urandom_range(40)) - 20);
          default: send_request(ppc_pkg::OP_TEST,
                     int'(bmin_x) + int'($urandom_range(int'(bmax_x) - int'(bmin_x))),
                     int'(bmin_y) + int'($urandom_range(int'(bmax_y) - int'(bmin_y))));
        endcase
      end
      sent += nverts + 7;
    end
  endtask

  initial begin
    send_idle_pct = 21;
    recv_idle_pct = 65;
    poly_count = 0;
    bmin_x = '0; bmin_y = '0; bmax_x = '0; bmax_y = '0;
    tested_points = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random(55);
    send_idle_pct = 65;
    recv_idle_pct = 21;
    test_random(55);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(55);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d results: %0d point tests (%0d inside), %0d refused appends.",
             result_count, tested_points, inside_points, refused_appends);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[polygon_point_containment_top.f]
rtl/ppc_pkg.sv
rtl/ppc_ram.sv
rtl/ppc_ctrl.sv
rtl/ppc_dp.sv
rtl/polygon_point_containment_top.sv
bench/polygon_point_containment_top_test.sv
